// ===== rtl/core/assert_macros.svh =====
// Assertion macros for the RTL modules of the encoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on the rising edge of clk, off while rst_n is low.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/sbue_pkg.sv =====
// Package with the types, codes, constants and byte-order helpers of the encoder.
`default_nettype none

package sbue_pkg;

    localparam int TBL_DEPTH = 256;
    localparam int ADDR_W    = $clog2(TBL_DEPTH);
    localparam int CP_W      = 32;
    localparam int ENTRY_W   = CP_W + 1;
    localparam int BUF_BYTES = 8;
    localparam int BUF_W     = 8 * BUF_BYTES;
    localparam int CNT_W     = $clog2(BUF_BYTES + 1);

    // Operation codes carried by the op field.
    localparam logic [1:0] OP_CONVERT = 2'd0;
    localparam logic [1:0] OP_LOAD    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Target forms.
    localparam logic [1:0] FORM_UCS2  = 2'd0;
    localparam logic [1:0] FORM_UTF16 = 2'd1;
    localparam logic [1:0] FORM_UTF32 = 2'd2;
    localparam logic [1:0] FORM_UCS4  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET_FORM   = 2'd0;
    localparam logic [1:0] REG_LITTLE_ENDIAN = 2'd1;
    localparam logic [1:0] REG_EMIT_BOM      = 2'd2;
    localparam logic [1:0] REG_REPLACEMENT   = 2'd3;

    localparam logic [CP_W-1:0] CP_BMP_MAX     = 32'h0000_FFFF;
    localparam logic [CP_W-1:0] CP_UNICODE_MAX = 32'h0010_FFFF;
    localparam logic [CP_W-1:0] CP_UCS4_MAX    = 32'h7FFF_FFFF;
    localparam logic [CP_W-1:0] CP_NONCHAR_FE  = 32'h0000_FFFE;
    localparam logic [CP_W-1:0] CP_NONCHAR_FF  = 32'h0000_FFFF;
    localparam logic [CP_W-1:0] CP_SURR_LO     = 32'h0000_D800;
    localparam logic [CP_W-1:0] CP_SURR_HI     = 32'h0000_DFFF;
    localparam logic [20:0]     CP_SUPP_BASE   = 21'h01_0000;
    localparam logic [5:0]      HI_SURR_TAG    = 6'b110110;
    localparam logic [5:0]      LO_SURR_TAG    = 6'b110111;
    localparam logic [15:0]     BOM_UNIT       = 16'hFEFF;

    // Work handed from the encode stage to the byte serializer.
    typedef struct packed {
        logic [BUF_W-1:0] bytes;     // left-justified, first byte in the top bits
        logic [CNT_W-1:0] count;     // number of bytes, 1 to 8
        logic             status;
        logic             replaced;
    } ser_load_t;

    // Puts a 16-bit unit into transmission order, first byte in the top bits.
    function automatic logic [15:0] order2(input logic [15:0] unit, input logic le);
        order2 = le ? {unit[7:0], unit[15:8]} : unit;
    endfunction

    // Puts a 32-bit unit into transmission order, first byte in the top bits.
    function automatic logic [31:0] order4(input logic [31:0] unit, input logic le);
        order4 = le ? {unit[7:0], unit[15:8], unit[23:16], unit[31:24]} : unit;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sbue_table.sv =====
// Code table memory: 256 entries of code point plus illegal mark, registered read.
`default_nettype none

module sbue_table
(
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [sbue_pkg::ADDR_W-1:0]    waddr,
    input  wire logic [sbue_pkg::ENTRY_W-1:0]   wdata,
    input  wire logic                           re,
    input  wire logic [sbue_pkg::ADDR_W-1:0]    raddr,
    output logic      [sbue_pkg::ENTRY_W-1:0]   rdata
);

    logic [sbue_pkg::ENTRY_W-1:0] mem [sbue_pkg::TBL_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // The read register holds its value while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sbue_serializer.sv =====
// Byte serializer: holds one encoded character and emits it one byte per transaction.
`default_nettype none

`include "assert_macros.svh"

module sbue_serializer
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   load,
    input  wire sbue_pkg::ser_load_t    load_data,
    output logic                        ready,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [7:0]                  out_byte,
    output logic                        last,
    output logic                        status,
    output logic                        replaced
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [sbue_pkg::BUF_W-1:0]     buf_reg;
    logic [sbue_pkg::BUF_W-1:0]     buf_next;
    logic [sbue_pkg::CNT_W-1:0]     cnt_reg;
    logic [sbue_pkg::CNT_W-1:0]     cnt_next;
    logic                           status_reg;
    logic                           status_next;
    logic                           repl_reg;
    logic                           repl_next;
    logic                           take;

    assign take      = valid_reg && !out_stall;
    assign last      = (cnt_reg == sbue_pkg::CNT_W'(1));
    assign ready     = !valid_reg || (take && last);
    assign out_valid = valid_reg;
    assign out_byte  = buf_reg[sbue_pkg::BUF_W-1 -: 8];
    assign status    = status_reg;
    assign replaced  = repl_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        buf_next    = buf_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        repl_next   = repl_reg;
        if (load)
        begin
            valid_next  = 1'b1;
            buf_next    = load_data.bytes;
            cnt_next    = load_data.count;
            status_next = load_data.status;
            repl_next   = load_data.replaced;
        end
        else if (take)
        begin
            if (last)
            begin
                valid_next = 1'b0;
            end
            buf_next = {buf_reg[sbue_pkg::BUF_W-9:0], 8'h00};
            cnt_next = cnt_reg - sbue_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg    <= buf_next;
        status_reg <= status_next;
        repl_reg   <= repl_next;
    end

    `ASSERT_CLK(a_cnt_nonzero, valid_reg |-> (cnt_reg != '0 && cnt_reg <= sbue_pkg::CNT_W'(8)), "byte count out of range while valid")
    `ASSERT_CLK(a_error_single, (valid_reg && status_reg) |-> last, "error transaction is not a single byte")
    `ASSERT_CLK(a_no_gap, (take && !last) |=> valid_reg, "character bytes interrupted")
    `ASSERT_CLK(a_load_when_ready, load |-> ready, "serializer loaded while busy")

endmodule

`default_nettype wire

// ===== rtl/core/single_byte_to_ucs_encoder.sv =====
// Top level of the single-byte code page to UCS encoder.
// Usage:
// The input channel (in_valid, in_stall) carries one operation per transaction:
// convert a byte, load a code table entry, or restart the stream. The output
// channel (out_valid, out_stall) carries one encoded byte per transaction, with
// last marking the final byte caused by an input transaction; an illegal
// character gives a single transaction with status set and no data byte.
// A convert accepted at a clock edge issues the table memory read at that
// edge; the encode stage then loads the serializer's output register from the
// read data once the serializer is ready.
// Throughput: the output is one byte per cycle while out_stall is low, and a
// converted character gives two bytes for UCS-2 and BMP UTF-16, four for
// UTF-32, UCS-4 and surrogate pairs, plus two or four for a byte order mark,
// and one for an error. Loads and restarts produce nothing. The byte
// serializer sets this rate; a new input transaction is taken while the last
// byte of the previous character waits.
// Reset clears the pipeline, loads the register reset values and arms the byte
// order mark. The code table is not cleared and must be loaded before use.
// When the receiver stalls, the current byte holds, the encode stage fills, and
// then in_stall rises until the character drains.
`default_nettype none

module single_byte_to_ucs_encoder
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    // Configuration write port.
    input  wire logic           cfg_we,
    input  wire logic [1:0]     cfg_index,
    input  wire logic [15:0]    cfg_data,
    // Input channel.
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [1:0]     op,
    input  wire logic [7:0]     in_byte,
    input  wire logic [31:0]    entry_value,
    input  wire logic           entry_illegal,
    // Output channel.
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [7:0]          out_byte,
    output logic                last,
    output logic                status,
    output logic                replaced
);

    // Configuration registers.
    logic [1:0]     target_form_reg;
    logic           little_endian_reg;
    logic           emit_bom_reg;
    logic [15:0]    replacement_reg;

    // Encode stage control and stream state.
    logic           s1_valid_reg;
    logic           s1_valid_next;
    logic [1:0]     s1_op_reg;
    logic           bom_pending_reg;
    logic           bom_pending_next;

    logic           in_accept;
    logic           s1_advance;
    logic           ser_ready;
    logic           ser_load;
    logic [sbue_pkg::ENTRY_W-1:0] entry;
    sbue_pkg::ser_load_t          load_data;

    // Encode datapath signals.
    logic [31:0]    cp_raw;
    logic           cp_illegal;
    logic [31:0]    cp;
    logic           repl;
    logic           err;
    logic           four;
    logic           pair;
    logic [20:0]    supp;
    logic [31:0]    char_bytes;
    logic [15:0]    char_bytes2;
    logic [31:0]    bom_bytes4;
    logic [15:0]    bom_bytes2;
    logic           bom_on;

    // The user writes configuration only while the block is idle; unenforced.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_form_reg   <= sbue_pkg::FORM_UTF16;
            little_endian_reg <= 1'b0;
            emit_bom_reg      <= 1'b1;
            replacement_reg   <= 16'hFFFD;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                sbue_pkg::REG_TARGET_FORM:   target_form_reg   <= cfg_data[1:0];
                sbue_pkg::REG_LITTLE_ENDIAN: little_endian_reg <= cfg_data[0];
                sbue_pkg::REG_EMIT_BOM:      emit_bom_reg      <= cfg_data[0];
                sbue_pkg::REG_REPLACEMENT:   replacement_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // Stage 0: the accepted transaction addresses the table. A load writes the
    // entry; a convert reads it, and the data is ready in the encode stage.
    // A load followed at once by a convert of the same byte is safe because
    // the write completes at the edge before the read.
    assign in_accept = in_valid && !in_stall;

    sbue_table u_table
    (
        .clk   (clk),
        .we    (in_accept && (op == sbue_pkg::OP_LOAD)),
        .waddr (in_byte),
        .wdata ({entry_illegal, entry_value}),
        .re    (in_accept && (op == sbue_pkg::OP_CONVERT)),
        .raddr (in_byte),
        .rdata (entry)
    );

    // Stage 1 only waits when it holds a convert and the serializer is busy.
    assign s1_advance    = (s1_op_reg != sbue_pkg::OP_CONVERT) || ser_ready;
    assign in_stall      = s1_valid_reg && !s1_advance;
    assign s1_valid_next = in_accept || (s1_valid_reg && !s1_advance);
    assign ser_load      = s1_valid_reg && (s1_op_reg == sbue_pkg::OP_CONVERT) && ser_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_op_reg    <= sbue_pkg::OP_CONVERT;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (in_accept)
            begin
                s1_op_reg <= op;
            end
        end
    end

    // Encode: replacement, validity check on the replaced value, surrogate
    // split and byte ordering, all into one left-justified byte buffer.
    assign cp_raw     = entry[31:0];
    assign cp_illegal = entry[32];
    assign four       = target_form_reg[1];

    always_comb
    begin
        cp   = cp_raw;
        repl = 1'b0;
        if (!cp_illegal)
        begin
            if ((target_form_reg == sbue_pkg::FORM_UCS2) && (cp_raw > sbue_pkg::CP_BMP_MAX))
            begin
                cp   = {16'h0000, replacement_reg};
                repl = 1'b1;
            end
            else if (((target_form_reg == sbue_pkg::FORM_UTF16)
                      || (target_form_reg == sbue_pkg::FORM_UTF32))
                     && (cp_raw > sbue_pkg::CP_UNICODE_MAX))
            begin
                cp   = {16'h0000, replacement_reg};
                repl = 1'b1;
            end
        end
    end

    assign err = cp_illegal
                 || (cp == sbue_pkg::CP_NONCHAR_FE)
                 || (cp == sbue_pkg::CP_NONCHAR_FF)
                 || (cp > sbue_pkg::CP_UCS4_MAX)
                 || ((cp >= sbue_pkg::CP_SURR_LO) && (cp <= sbue_pkg::CP_SURR_HI));

    // A valid code point above the BMP in UTF-16 is at most U+10FFFF here.
    assign pair = (target_form_reg == sbue_pkg::FORM_UTF16) && (cp > sbue_pkg::CP_BMP_MAX);
    assign supp = cp[20:0] - sbue_pkg::CP_SUPP_BASE;

    assign bom_on      = bom_pending_reg && emit_bom_reg;
    assign bom_bytes2  = sbue_pkg::order2(sbue_pkg::BOM_UNIT, little_endian_reg);
    assign bom_bytes4  = sbue_pkg::order4({16'h0000, sbue_pkg::BOM_UNIT}, little_endian_reg);
    assign char_bytes2 = sbue_pkg::order2(cp[15:0], little_endian_reg);

    always_comb
    begin
        if (four)
        begin
            char_bytes = sbue_pkg::order4(cp, little_endian_reg);
        end
        else
        begin
            char_bytes = {sbue_pkg::order2({sbue_pkg::HI_SURR_TAG, supp[19:10]},
                                           little_endian_reg),
                          sbue_pkg::order2({sbue_pkg::LO_SURR_TAG, supp[9:0]},
                                           little_endian_reg)};
        end
    end

    always_comb
    begin
        load_data.status   = 1'b0;
        load_data.replaced = repl;
        if (err)
        begin
            load_data.bytes    = '0;
            load_data.count    = sbue_pkg::CNT_W'(1);
            load_data.status   = 1'b1;
            load_data.replaced = 1'b0;
        end
        else if (four || pair)
        begin
            if (!bom_on)
            begin
                load_data.bytes = {char_bytes, 32'h0};
                load_data.count = sbue_pkg::CNT_W'(4);
            end
            else if (four)
            begin
                load_data.bytes = {bom_bytes4, char_bytes};
                load_data.count = sbue_pkg::CNT_W'(8);
            end
            else
            begin
                load_data.bytes = {bom_bytes2, char_bytes, 16'h0};
                load_data.count = sbue_pkg::CNT_W'(6);
            end
        end
        else
        begin
            if (bom_on)
            begin
                load_data.bytes = {bom_bytes2, char_bytes2, 32'h0};
                load_data.count = sbue_pkg::CNT_W'(4);
            end
            else
            begin
                load_data.bytes = {char_bytes2, 48'h0};
                load_data.count = sbue_pkg::CNT_W'(2);
            end
        end
    end

    // The mark is re-armed by a restart and consumed by a good character.
    always_comb
    begin
        bom_pending_next = bom_pending_reg;
        if (s1_valid_reg && (s1_op_reg == sbue_pkg::OP_RESTART))
        begin
            bom_pending_next = emit_bom_reg;
        end
        else if (ser_load && !err)
        begin
            bom_pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bom_pending_reg <= 1'b1;
        end
        else
        begin
            bom_pending_reg <= bom_pending_next;
        end
    end

    sbue_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ser_load),
        .load_data (load_data),
        .ready     (ser_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .last      (last),
        .status    (status),
        .replaced  (replaced)
    );

endmodule

`default_nettype wire
